// ----- sv/dqsd_pkg.sv -----
// Package: sizes, operation and status codes, state type and ring helper for the deque.
`default_nettype none
package dqsd_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  // Operation codes
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_SEARCH     = 3'd4;
  localparam logic [2:0] OP_DUMP       = 3'd5;

  // Result status codes
  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_ELEMENT   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_DUMP   = 3'b100
  } state_t;

  // Ring slot of an element at a given offset from the front
  function automatic logic [IDX_W-1:0] ring_slot(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- sv/dqsd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module dqsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/deque_with_search_dump.sv -----
// Bounded double-ended queue in a ring RAM, with search and front-to-back dump.
// Push and pop give no result and leave busy low; a push into a full queue gives one result next cycle.
// Search or dump on an empty queue: one result in the cycle after the transfer, busy stays low.
// Search: one RAM read per cycle; busy stays high until the result.
// Dump: count results back to back, from the front to the back.
// Reset (synchronous, rst_n low) empties the queue; RAM contents are not cleared.
`default_nettype none
module deque_with_search_dump (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic        [2:0]                      in_operation,
  input  wire logic signed [dqsd_pkg::DATA_W-1:0]     in_value,
  output logic                                        out_valid,
  output logic             [2:0]                      out_status,
  output logic signed      [dqsd_pkg::DATA_W-1:0]     out_element,
  output logic                                        out_last
);

  dqsd_pkg::state_t                   state_r, state_nxt;
  logic [dqsd_pkg::IDX_W-1:0]         front_r, front_nxt;
  logic [dqsd_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic [dqsd_pkg::CNT_W-1:0]         rd_i_r, rd_i_nxt;
  logic [dqsd_pkg::IDX_W-1:0]         cmp_i_r, cmp_i_nxt;
  logic                               rd_pend_r, rd_pend_nxt;
  logic [dqsd_pkg::DATA_W-1:0]        key_r, key_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [2:0]                         out_status_r, out_status_nxt;
  logic [dqsd_pkg::DATA_W-1:0]        out_element_r, out_element_nxt;
  logic                               out_last_r, out_last_nxt;

  logic                               ram_we;
  logic [dqsd_pkg::IDX_W-1:0]         ram_waddr;
  logic [dqsd_pkg::IDX_W-1:0]         ram_raddr;
  logic [dqsd_pkg::DATA_W-1:0]        ram_rdata;

  logic                               accept;
  logic                               is_empty;
  logic                               is_full;
  logic                               issue;
  logic                               at_back;

  assign busy        = (state_r != dqsd_pkg::S_IDLE);
  assign accept      = start && !busy;
  assign is_empty    = (count_r == '0);
  assign is_full     = (count_r == dqsd_pkg::CNT_W'(dqsd_pkg::DEPTH));
  assign issue       = (rd_i_r < count_r);
  assign at_back     = ({1'b0, cmp_i_r} == (count_r - dqsd_pkg::CNT_W'(1)));
  assign ram_raddr   = dqsd_pkg::ring_slot(front_r, rd_i_r[dqsd_pkg::IDX_W-1:0]);

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;

  dqsd_ram #(
    .WIDTH (dqsd_pkg::DATA_W),
    .DEPTH (dqsd_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Decode commands in idle; walk the ring one read per cycle in search and dump
  always_comb begin
    state_nxt       = state_r;
    front_nxt       = front_r;
    count_nxt       = count_r;
    rd_i_nxt        = rd_i_r;
    cmp_i_nxt       = cmp_i_r;
    rd_pend_nxt     = 1'b0;
    key_nxt         = key_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_element_nxt = '0;
    out_last_nxt    = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = dqsd_pkg::ring_slot(front_r, count_r[dqsd_pkg::IDX_W-1:0]);

    case (state_r)
      dqsd_pkg::S_IDLE: begin
        if (accept) begin
          case (in_operation)
            dqsd_pkg::OP_PUSH_FRONT, dqsd_pkg::OP_PUSH_BACK: begin
              if (is_full) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = dqsd_pkg::ST_FULL;
                out_last_nxt   = 1'b1;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + dqsd_pkg::CNT_W'(1);
                if (in_operation == dqsd_pkg::OP_PUSH_FRONT) begin
                  front_nxt = dqsd_pkg::ring_slot(front_r,
                                                  dqsd_pkg::IDX_W'(dqsd_pkg::DEPTH - 1));
                  ram_waddr = front_nxt;
                end
              end
            end
            dqsd_pkg::OP_POP_FRONT: begin
              if (!is_empty) begin
                front_nxt = dqsd_pkg::ring_slot(front_r, dqsd_pkg::IDX_W'(1));
                count_nxt = count_r - dqsd_pkg::CNT_W'(1);
              end
            end
            dqsd_pkg::OP_POP_BACK: begin
              if (!is_empty) begin
                count_nxt = count_r - dqsd_pkg::CNT_W'(1);
              end
            end
            dqsd_pkg::OP_SEARCH, dqsd_pkg::OP_DUMP: begin
              if (is_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = dqsd_pkg::ST_EMPTY;
                out_last_nxt   = 1'b1;
              end else begin
                key_nxt   = in_value;
                rd_i_nxt  = '0;
                state_nxt = (in_operation == dqsd_pkg::OP_SEARCH) ?
                            dqsd_pkg::S_SEARCH : dqsd_pkg::S_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      dqsd_pkg::S_SEARCH, dqsd_pkg::S_DUMP: begin
        // advance the read pointer while live entries remain
        if (issue) begin
          rd_i_nxt = rd_i_r + dqsd_pkg::CNT_W'(1);
        end
        rd_pend_nxt = issue;
        cmp_i_nxt   = rd_i_r[dqsd_pkg::IDX_W-1:0];

        // consume the entry read in the previous cycle
        if (rd_pend_r) begin
          if (state_r == dqsd_pkg::S_SEARCH) begin
            if (ram_rdata == key_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = dqsd_pkg::ST_FOUND;
              out_last_nxt   = 1'b1;
              state_nxt      = dqsd_pkg::S_IDLE;
              rd_pend_nxt    = 1'b0;
            end else if (at_back) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = dqsd_pkg::ST_NOT_FOUND;
              out_last_nxt   = 1'b1;
              state_nxt      = dqsd_pkg::S_IDLE;
              rd_pend_nxt    = 1'b0;
            end
          end else begin
            out_valid_nxt   = 1'b1;
            out_status_nxt  = dqsd_pkg::ST_ELEMENT;
            out_element_nxt = ram_rdata;
            out_last_nxt    = at_back;
            if (at_back) begin
              state_nxt   = dqsd_pkg::S_IDLE;
              rd_pend_nxt = 1'b0;
            end
          end
        end
      end

      default: begin
        state_nxt = dqsd_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dqsd_pkg::S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      rd_i_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      rd_i_r      <= rd_i_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmp_i_r       <= cmp_i_nxt;
    key_r         <= key_nxt;
    out_status_r  <= out_status_nxt;
    out_element_r <= out_element_nxt;
    out_last_r    <= out_last_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= dqsd_pkg::CNT_W'(dqsd_pkg::DEPTH))
    else $error("element count above depth");

  a_walk_ends_in_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid && out_last)
    else $error("walk ended without a final transfer");

  a_only_dump_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == dqsd_pkg::ST_ELEMENT && busy)
    else $error("non-final transfer outside a dump");

  a_write_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == dqsd_pkg::S_IDLE && !rd_pend_r)
    else $error("ring written during a walk");
`endif

endmodule
`default_nettype wire

// ----- tb/deque_with_search_dump_checker.sv -----
`timescale 1ns / 1ps
// Checker for the deque: shadow ring that predicts every result and compares it at the strobe.
module deque_with_search_dump_checker (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic                               busy,
  input  wire logic        [2:0]                  in_operation,
  input  wire logic signed [dqsd_pkg::DATA_W-1:0] in_value,
  input  wire logic                               out_valid,
  input  wire logic        [2:0]                  out_status,
  input  wire logic signed [dqsd_pkg::DATA_W-1:0] out_element,
  input  wire logic                               out_last,
  output int                                      fail_count,
  output int                                      pending
);

  typedef struct packed {
    logic        [2:0]                  status;
    logic signed [dqsd_pkg::DATA_W-1:0] element;
    logic                               last;
  } deque_result_t;

  // Shadow copy of the ring, its front slot and its fill level
  logic signed [dqsd_pkg::DATA_W-1:0] ring_store [dqsd_pkg::DEPTH];
  logic        [dqsd_pkg::IDX_W-1:0]  ring_front;
  logic        [dqsd_pkg::CNT_W-1:0]  ring_count;

  deque_result_t awaited_results[$];
  deque_result_t oldest;
  int            mismatches = 0;

  function automatic logic [dqsd_pkg::IDX_W-1:0] slot_at(input int offset);
    return dqsd_pkg::IDX_W'((int'(ring_front) + offset) % dqsd_pkg::DEPTH);
  endfunction

  task automatic await_result(input logic [2:0] status,
                              input logic signed [dqsd_pkg::DATA_W-1:0] element,
                              input logic last);
    deque_result_t r;
    r.status  = status;
    r.element = element;
    r.last    = last;
    awaited_results.push_back(r);
  endtask

  // Apply one accepted command to the shadow ring and queue the results it causes
  task automatic apply_command(input logic [2:0] op,
                               input logic signed [dqsd_pkg::DATA_W-1:0] val);
    bit hit;
    int i;
    hit = 1'b0;
    case (op)
      dqsd_pkg::OP_PUSH_FRONT, dqsd_pkg::OP_PUSH_BACK: begin
        if (ring_count >= dqsd_pkg::DEPTH) begin
          await_result(dqsd_pkg::ST_FULL, '0, 1'b1);
        end else begin
          if (op == dqsd_pkg::OP_PUSH_FRONT) begin
            ring_front = slot_at(dqsd_pkg::DEPTH - 1);
            ring_store[ring_front] = val;
          end else begin
            ring_store[slot_at(int'(ring_count))] = val;
          end
          ring_count = ring_count + 1'b1;
        end
      end
      dqsd_pkg::OP_POP_FRONT: begin
        if (ring_count != 0) begin
          ring_front = slot_at(1);
          ring_count = ring_count - 1'b1;
        end
      end
      dqsd_pkg::OP_POP_BACK: begin
        if (ring_count != 0) ring_count = ring_count - 1'b1;
      end
      dqsd_pkg::OP_SEARCH: begin
        if (ring_count == 0) begin
          await_result(dqsd_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < int'(ring_count); i++) begin
            if (ring_store[slot_at(i)] == val) hit = 1'b1;
          end
          await_result(hit ? dqsd_pkg::ST_FOUND : dqsd_pkg::ST_NOT_FOUND, '0, 1'b1);
        end
      end
      dqsd_pkg::OP_DUMP: begin
        if (ring_count == 0) begin
          await_result(dqsd_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < int'(ring_count); i++) begin
            await_result(dqsd_pkg::ST_ELEMENT, ring_store[slot_at(i)],
                         i + 1 == int'(ring_count));
          end
        end
      end
      default: begin
        // undefined codes: drop silently
      end
    endcase
  endtask

  // Predict on each input transfer, then compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      ring_front = '0;
      ring_count = '0;
      awaited_results.delete();
    end else begin
      if (start && !busy) apply_command(in_operation, in_value);
      if ($isunknown(out_valid)) begin
        $error("out_valid unknown: %b", out_valid);
        mismatches++;
      end else if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: status %0d element %0d last %0b",
                 out_status, out_element, out_last);
          mismatches++;
        end else begin
          oldest = awaited_results.pop_front();
          if (out_status !== oldest.status) begin
            $error("out_status: expected %0d, actual %0d", oldest.status, out_status);
            mismatches++;
          end
          if (out_element !== oldest.element) begin
            $error("out_element: expected %0d, actual %0d", oldest.element, out_element);
            mismatches++;
          end
          if (out_last !== oldest.last) begin
            $error("out_last: expected %0b, actual %0b", oldest.last, out_last);
            mismatches++;
          end
        end
      end
    end
    fail_count <= mismatches;
    pending    <= awaited_results.size();
  end

endmodule

// ----- tb/deque_with_search_dump_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the deque: clock, reset, command stimulus and the final verdict.
module deque_with_search_dump_tb;

  // Codes the block must ignore
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  localparam int PHASES     = 6;
  localparam int PHASE_CMDS = 30;

  logic                               clk          = 1'b0;
  logic                               rst_n        = 1'b0;
  logic                               start        = 1'b0;
  logic        [2:0]                  in_operation = dqsd_pkg::OP_PUSH_FRONT;
  logic signed [dqsd_pkg::DATA_W-1:0] in_value     = '0;

  wire logic                               busy;
  wire logic                               out_valid;
  wire logic        [2:0]                  out_status;
  wire logic signed [dqsd_pkg::DATA_W-1:0] out_element;
  wire logic                               out_last;

  int fail_count;
  int pending;
  int idle_pct;
  int fill_level;

  deque_with_search_dump uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_operation(in_operation),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_element (out_element),
    .out_last    (out_last)
  );

  deque_with_search_dump_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_operation(in_operation),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_element (out_element),
    .out_last    (out_last),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Mostly random words, some from a small pool so searches hit, some at the extremes
  function automatic logic signed [dqsd_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(3))
      0, 1:    return dqsd_pkg::DATA_W'($urandom);
      2:       return dqsd_pkg::DATA_W'(int'($urandom_range(15)) - 8);
      default: begin
        case ($urandom_range(3))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return '0;
          default: return -32'sd1;
        endcase
      end
    endcase
  endfunction

  // Choose an operation, leaning towards pushes while filling and pops while draining
  function automatic logic [2:0] pick_operation(input bit filling);
    int r;
    int push_share;
    int pop_share;
    r          = $urandom_range(99);
    push_share = filling ? 62 : 20;
    pop_share  = filling ? 14 : 56;
    if (r < push_share) begin
      return $urandom_range(1) ? dqsd_pkg::OP_PUSH_BACK : dqsd_pkg::OP_PUSH_FRONT;
    end
    if (r < push_share + pop_share) begin
      return $urandom_range(1) ? dqsd_pkg::OP_POP_BACK : dqsd_pkg::OP_POP_FRONT;
    end
    if (r < push_share + pop_share + 14) return dqsd_pkg::OP_SEARCH;
    if (r < push_share + pop_share + 20) return dqsd_pkg::OP_DUMP;
    return $urandom_range(1) ? OP_SPARE_B : OP_SPARE_A;
  endfunction

  // Offer one command, idling first at the current rate, and hold it until the transfer
  task automatic send_command(input logic [2:0] op,
                              input logic signed [dqsd_pkg::DATA_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      start        <= 1'b0;
      in_operation <= 3'($urandom);
      in_value     <= dqsd_pkg::DATA_W'($urandom);
      @(posedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_value     <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    // track the fill level only to steer the stimulus
    case (op)
      dqsd_pkg::OP_PUSH_FRONT, dqsd_pkg::OP_PUSH_BACK: begin
        if (fill_level < dqsd_pkg::DEPTH) fill_level++;
      end
      dqsd_pkg::OP_POP_FRONT, dqsd_pkg::OP_POP_BACK: begin
        if (fill_level > 0) fill_level--;
      end
      default: ;
    endcase
  endtask

  // Hold off the sender until every predicted result has been seen
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int phase;
    int n;
    int guard;
    idle_pct   = 0;
    fill_level = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty queue cases, ignored codes, extremes, wrap of the front slot
    send_command(dqsd_pkg::OP_DUMP, '0);
    send_command(dqsd_pkg::OP_SEARCH, '0);
    send_command(dqsd_pkg::OP_POP_FRONT, 32'sh1234_5678);
    send_command(dqsd_pkg::OP_POP_BACK, -32'sd1);
    send_command(OP_SPARE_A, 32'sh7FFF_FFFF);
    send_command(OP_SPARE_B, 32'sh8000_0000);
    send_command(dqsd_pkg::OP_PUSH_BACK, 32'sh7FFF_FFFF);
    send_command(dqsd_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
    send_command(dqsd_pkg::OP_PUSH_BACK, '0);
    send_command(dqsd_pkg::OP_PUSH_BACK, -32'sd1);
    send_command(dqsd_pkg::OP_SEARCH, 32'sh8000_0000);
    send_command(dqsd_pkg::OP_SEARCH, 32'sh7FFF_FFFF);
    send_command(dqsd_pkg::OP_SEARCH, 32'sd1);
    send_command(dqsd_pkg::OP_SEARCH, -32'sd1);
    send_command(dqsd_pkg::OP_DUMP, '0);
    send_command(dqsd_pkg::OP_POP_FRONT, '0);
    send_command(dqsd_pkg::OP_POP_BACK, '0);
    send_command(dqsd_pkg::OP_DUMP, '0);
    send_command(OP_SPARE_A, '0);
    send_command(OP_SPARE_B, -32'sd1);
    send_command(dqsd_pkg::OP_POP_FRONT, '0);
    send_command(dqsd_pkg::OP_POP_BACK, '0);
    send_command(dqsd_pkg::OP_DUMP, '0);
    drain_results();

    // Random phases: alternate filling and draining under different idle rates
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 57;
        default: idle_pct = 14;
      endcase
      for (n = 0; n < PHASE_CMDS; n++) begin
        send_command(pick_operation(phase % 2 == 0), pick_value());
      end
    end
    drain_results();

    // Fill to the brim, overflow from both ends, walk the full ring, then empty it
    idle_pct = 14;
    while (fill_level < dqsd_pkg::DEPTH) begin
      send_command($urandom_range(1) ? dqsd_pkg::OP_PUSH_BACK : dqsd_pkg::OP_PUSH_FRONT,
                   pick_value());
    end
    send_command(dqsd_pkg::OP_PUSH_FRONT, pick_value());
    send_command(dqsd_pkg::OP_PUSH_BACK, pick_value());
    send_command(dqsd_pkg::OP_SEARCH, dqsd_pkg::DATA_W'(int'($urandom_range(15)) - 8));
    send_command(dqsd_pkg::OP_SEARCH, pick_value());
    send_command(dqsd_pkg::OP_DUMP, '0);
    send_command(dqsd_pkg::OP_PUSH_BACK, pick_value());
    idle_pct = 57;
    while (fill_level > 0) begin
      send_command($urandom_range(1) ? dqsd_pkg::OP_POP_BACK : dqsd_pkg::OP_POP_FRONT,
                   pick_value());
    end
    send_command(dqsd_pkg::OP_POP_BACK, pick_value());
    send_command(dqsd_pkg::OP_SEARCH, pick_value());
    send_command(dqsd_pkg::OP_DUMP, '0);

    // Wind down: wait for the last results, then let the pipeline settle
    start <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (pending != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (dqsd_pkg::DEPTH + 8) @(posedge clk);
    if (pending != 0) $error("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
